// File: rtl/core/sorted_grid_fractional_index_top_assert.svh
// Assertion macros for the sorted grid fractional index block
`ifndef SORTED_GRID_FRACTIONAL_INDEX_TOP_ASSERT_SVH
`define SORTED_GRID_FRACTIONAL_INDEX_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define SGFI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sgfi assertion failed");

// next-cycle implication
`define SGFI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sgfi assertion failed");

`endif

// File: rtl/core/sgfi_pkg.sv
// Types, codes and helpers shared by the sorted grid fractional index block
package sgfi_pkg;

   localparam int COORD_W = 32;
   localparam int CMP_W   = 34;
   localparam int INDEX_W = 25;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FEW   = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETTLE,
      S_COMMIT,
      S_FETCH_FIRST,
      S_FETCH_LAST,
      S_CHECK,
      S_SEARCH,
      S_PREP,
      S_DIVIDE,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic                      commit;
      logic                      sort_order;
      logic signed [COORD_W-1:0] coordinate;
   } cell_ctl_type;

   // a must stand strictly ahead of b in the given order
   function automatic logic ahead_of(input logic order,
                                     input logic signed [CMP_W-1:0] a,
                                     input logic signed [CMP_W-1:0] b);
      ahead_of = order ? (a > b) : (a < b);
   endfunction

endpackage

// File: rtl/core/sgfi_cell.sv
// One table cell: holds a coordinate, settles the insert flag, drives the read bus
module sgfi_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IW         = 8,
   parameter int CW         = 9
) (
   input  logic                               clock,
   input  sgfi_pkg::cell_ctl_type             ctl_i,
   input  logic [CW-1:0]                      count_i,
   input  logic [IW-1:0]                      read_addr_i,
   input  logic signed [sgfi_pkg::COORD_W-1:0] left_value_i,
   input  logic                               left_flag_i,
   input  logic                               right_flag_i,
   output logic signed [sgfi_pkg::COORD_W-1:0] value_o,
   output logic                               flag_o,
   output logic [sgfi_pkg::COORD_W-1:0]       read_data_o
);

   logic signed [sgfi_pkg::COORD_W-1:0] value_ff, value_in;
   logic                                flag_ff, flag_in;
   logic [sgfi_pkg::COORD_W-1:0]        rd_ff, rd_in;
   logic                                occupied, goes_before;

   always_comb begin
      occupied    = CW'(CELL_INDEX) < count_i;
      goes_before = sgfi_pkg::ahead_of(ctl_i.sort_order,
                       sgfi_pkg::CMP_W'($signed(ctl_i.coordinate)),
                       sgfi_pkg::CMP_W'(value_ff));
      flag_in     = occupied ? (goes_before & right_flag_i) : 1'b1;
      value_in    = value_ff;
      if (ctl_i.commit && flag_ff) begin
         value_in = left_flag_i ? left_value_i : ctl_i.coordinate;
      end
      rd_in = (read_addr_i == IW'(CELL_INDEX)) ? value_ff : '0;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      flag_ff  <= flag_in;
      rd_ff    <= rd_in;
   end

   assign value_o     = value_ff;
   assign flag_o      = flag_ff;
   assign read_data_o = rd_ff;

endmodule

// File: rtl/core/sgfi_div.sv
// Restoring divider, one quotient bit per cycle, for num < den
module sgfi_div #(
   parameter int QUOT_W = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start_i,
   input  logic [sgfi_pkg::COORD_W-1:0] num_i,
   input  logic [sgfi_pkg::COORD_W-1:0] den_i,
   output logic                         done_o,
   output logic [QUOT_W-1:0]            quot_o
);

   localparam int KW = $clog2(QUOT_W + 1);

   logic                         active_ff, active_in;
   logic                         done_ff, done_in;
   logic [KW-1:0]                cnt_ff, cnt_in;
   logic [sgfi_pkg::COORD_W-1:0] rem_ff, rem_in;
   logic [sgfi_pkg::COORD_W-1:0] den_ff, den_in;
   logic [QUOT_W-1:0]            quot_ff, quot_in;
   logic [sgfi_pkg::COORD_W:0]   rem2, diff;
   logic                         ge;

   always_comb begin
      rem2      = {rem_ff, 1'b0};
      diff      = rem2 - {1'b0, den_ff};
      ge        = rem2 >= {1'b0, den_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      if (start_i) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = num_i;
         den_in    = den_i;
      end else if (active_ff) begin
         rem_in  = ge ? diff[sgfi_pkg::COORD_W-1:0] : rem2[sgfi_pkg::COORD_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         cnt_in  = cnt_ff + KW'(1);
         if (cnt_ff == KW'(QUOT_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done_o = done_ff;
   assign quot_o = quot_ff;

endmodule

// File: rtl/core/sorted_grid_fractional_index_top.sv
// Sorted grid coordinate table with fractional index lookup
// The table lives in a row of MAX_POINTS cells. Clear and action code 3 load
// their answer word in the accept cycle. An insert settles a position flag that
// ripples one cell per cycle down the row and then shifts the row in one step.
// A query reads cells over a registered read bus: first and last entry, then
// one read per binary search step (ceil(log2(count - 1)) steps), a final check,
// then the serial divider and the hand-off of the word. A fraction of 0 or 1.0
// skips the divider. A query with fewer than two points or an insert into a
// full table answers at once with its status; a query outside the table answers
// once its first and last entry are read. A stalled result word holds the block
// until it is taken.
module sorted_grid_fractional_index_top #(
   parameter int MAX_POINTS    = 256,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,     // sort_order
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // coordinate [31:0], query_offset [63:32]
   input  logic [1:0]  req_tuser,     // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // fractional_index [24:0], zero fill
   output logic [1:0]  rsp_tuser      // status
);

   `include "sorted_grid_fractional_index_top_assert.svh"

   localparam int IW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int F     = FRACTION_BITS;
   localparam int RAW_W = IW + F + 1;
   localparam int SUM_W = (RAW_W > sgfi_pkg::INDEX_W) ? RAW_W : sgfi_pkg::INDEX_W;
   localparam int NW    = sgfi_pkg::CMP_W + 1;

   sgfi_pkg::fsm_type state_ff, state_in;

   logic                                order_ff;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       settle_ff, settle_in;
   logic signed [sgfi_pkg::COORD_W-1:0] coord_ff, coord_in;
   logic signed [sgfi_pkg::COORD_W-1:0] off_ff, off_in;
   logic signed [sgfi_pkg::CMP_W-1:0]   q_ff, q_in;
   logic signed [sgfi_pkg::COORD_W-1:0] first_ff, first_in;
   logic signed [sgfi_pkg::COORD_W-1:0] xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [IW-1:0]                       lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0]                       addr_ff, addr_in;
   logic [1:0]                          wait_ff, wait_in;
   logic signed [NW-1:0]                num_ff, num_in, den_ff, den_in;
   logic [sgfi_pkg::INDEX_W-1:0]        res_idx_ff, res_idx_in;
   logic [1:0]                          res_st_ff, res_st_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sgfi_pkg::INDEX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [1:0]                          rsp_st_ff, rsp_st_in;
   logic [sgfi_pkg::COORD_W-1:0]        bus_ff, bus_or;

   logic                  accept, slot_free, fetch_done, issue, load;
   logic [sgfi_pkg::INDEX_W-1:0] load_idx;
   logic [1:0]            load_st;
   logic [CW-1:0]         count_m1;
   logic [IW:0]           mid_sum;
   logic signed [sgfi_pkg::CMP_W-1:0] bus_s, first_s, off_s;
   logic                  out_of_range, hit_before;
   logic                  div_start, div_done;
   logic [F-1:0]          div_quot;
   sgfi_pkg::cell_ctl_type ctl;

   logic signed [sgfi_pkg::COORD_W-1:0] cell_value [MAX_POINTS];
   logic [MAX_POINTS-1:0]               cell_flag;
   logic [sgfi_pkg::COORD_W-1:0]        cell_rd [MAX_POINTS];

   function automatic logic [sgfi_pkg::INDEX_W-1:0] make_index(input logic [IW-1:0] lo,
                                                               input logic [F:0] frac);
      logic [SUM_W-1:0] sum;
      sum = (SUM_W'(lo) << F) + SUM_W'(frac);
      make_index = sum[sgfi_pkg::INDEX_W-1:0];
   endfunction

   // cell row
   assign ctl.commit     = (state_ff == sgfi_pkg::S_COMMIT);
   assign ctl.sort_order = order_ff;
   assign ctl.coordinate = coord_ff;

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic signed [sgfi_pkg::COORD_W-1:0] left_value;
      logic                                left_flag, right_flag;
      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_flag  = 1'b0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_flag  = cell_flag[i-1];
      end
      if (i == MAX_POINTS - 1) begin : g_last
         assign right_flag = 1'b1;
      end else begin : g_inner
         assign right_flag = cell_flag[i+1];
      end
      sgfi_cell #(.CELL_INDEX(i), .IW(IW), .CW(CW)) u_cell (
         .clock        (clock),
         .ctl_i        (ctl),
         .count_i      (count_ff),
         .read_addr_i  (addr_ff),
         .left_value_i (left_value),
         .left_flag_i  (left_flag),
         .right_flag_i (right_flag),
         .value_o      (cell_value[i]),
         .flag_o       (cell_flag[i]),
         .read_data_o  (cell_rd[i])
      );
   end

   always_comb begin
      bus_or = '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         bus_or = bus_or | cell_rd[i];
      end
   end

   sgfi_div #(.QUOT_W(F)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (div_start),
      .num_i   (num_ff[sgfi_pkg::COORD_W-1:0]),
      .den_i   (den_ff[sgfi_pkg::COORD_W-1:0]),
      .done_o  (div_done),
      .quot_o  (div_quot)
   );

   // handshake
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == sgfi_pkg::S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign fetch_done = (wait_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sgfi_pkg::S_IDLE: begin
            if (accept) begin
               if (req_tuser == sgfi_pkg::ACT_INSERT && count_ff != CW'(MAX_POINTS)) begin
                  state_in = sgfi_pkg::S_SETTLE;
               end else if (req_tuser == sgfi_pkg::ACT_QUERY && count_ff >= CW'(2)) begin
                  state_in = sgfi_pkg::S_FETCH_FIRST;
               end
            end
         end
         sgfi_pkg::S_SETTLE: begin
            if (settle_ff == CW'(MAX_POINTS)) state_in = sgfi_pkg::S_COMMIT;
         end
         sgfi_pkg::S_COMMIT:      state_in = sgfi_pkg::S_DONE;
         sgfi_pkg::S_FETCH_FIRST: if (fetch_done) state_in = sgfi_pkg::S_FETCH_LAST;
         sgfi_pkg::S_FETCH_LAST: begin
            if (fetch_done) state_in = out_of_range ? sgfi_pkg::S_DONE : sgfi_pkg::S_CHECK;
         end
         sgfi_pkg::S_CHECK: begin
            state_in = (hi_ff - lo_ff > IW'(1)) ? sgfi_pkg::S_SEARCH : sgfi_pkg::S_PREP;
         end
         sgfi_pkg::S_SEARCH: if (fetch_done) state_in = sgfi_pkg::S_CHECK;
         sgfi_pkg::S_PREP: begin
            if (den_ff <= 0 || num_ff <= 0 || num_ff >= den_ff) state_in = sgfi_pkg::S_DONE;
            else state_in = sgfi_pkg::S_DIVIDE;
         end
         sgfi_pkg::S_DIVIDE: if (div_done) state_in = sgfi_pkg::S_DONE;
         sgfi_pkg::S_DONE:   if (slot_free) state_in = sgfi_pkg::S_IDLE;
         default:            state_in = sgfi_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_m1     = count_ff - CW'(1);
      mid_sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
      bus_s        = sgfi_pkg::CMP_W'($signed(bus_ff));
      first_s      = sgfi_pkg::CMP_W'(first_ff);
      off_s        = sgfi_pkg::CMP_W'(off_ff);
      out_of_range = order_ff ? (q_ff > first_s || q_ff < bus_s)
                              : (q_ff < first_s || q_ff > bus_s);
      hit_before   = sgfi_pkg::ahead_of(order_ff, q_ff, bus_s);

      count_in   = count_ff;
      settle_in  = settle_ff;
      coord_in   = coord_ff;
      off_in     = off_ff;
      q_in       = q_ff;
      first_in   = first_ff;
      xlo_in     = xlo_ff;
      xhi_in     = xhi_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      addr_in    = addr_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      res_idx_in = res_idx_ff;
      res_st_in  = res_st_ff;
      issue      = 1'b0;
      load       = 1'b0;
      load_idx   = '0;
      load_st    = sgfi_pkg::ST_OK;
      div_start  = 1'b0;

      case (state_ff)
         sgfi_pkg::S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  sgfi_pkg::ACT_CLEAR: begin
                     count_in = '0;
                     load     = 1'b1;
                  end
                  sgfi_pkg::ACT_INSERT: begin
                     if (count_ff == CW'(MAX_POINTS)) begin
                        load    = 1'b1;
                        load_st = sgfi_pkg::ST_FULL;
                     end else begin
                        coord_in  = $signed(req_tdata[31:0]);
                        settle_in = '0;
                     end
                  end
                  sgfi_pkg::ACT_QUERY: begin
                     if (count_ff < CW'(2)) begin
                        load    = 1'b1;
                        load_st = sgfi_pkg::ST_FEW;
                     end else begin
                        off_in  = $signed(req_tdata[63:32]);
                        addr_in = '0;
                        issue   = 1'b1;
                     end
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         sgfi_pkg::S_SETTLE: settle_in = settle_ff + CW'(1);
         sgfi_pkg::S_COMMIT: begin
            count_in   = count_ff + CW'(1);
            res_idx_in = '0;
            res_st_in  = sgfi_pkg::ST_OK;
         end
         sgfi_pkg::S_FETCH_FIRST: begin
            if (fetch_done) begin
               first_in = $signed(bus_ff);
               q_in     = order_ff ? bus_s - off_s : bus_s + off_s;
               addr_in  = count_m1[IW-1:0];
               issue    = 1'b1;
            end
         end
         sgfi_pkg::S_FETCH_LAST: begin
            if (fetch_done) begin
               lo_in      = '0;
               hi_in      = count_m1[IW-1:0];
               xlo_in     = first_ff;
               xhi_in     = $signed(bus_ff);
               res_idx_in = '0;
               res_st_in  = sgfi_pkg::ST_RANGE;
            end
         end
         sgfi_pkg::S_CHECK: begin
            if (hi_ff - lo_ff > IW'(1)) begin
               addr_in = mid_sum[IW:1];
               issue   = 1'b1;
            end else if (order_ff) begin
               num_in = NW'(xlo_ff) - NW'(q_ff);
               den_in = NW'(xlo_ff) - NW'(xhi_ff);
            end else begin
               num_in = NW'(q_ff) - NW'(xlo_ff);
               den_in = NW'(xhi_ff) - NW'(xlo_ff);
            end
         end
         sgfi_pkg::S_SEARCH: begin
            if (fetch_done) begin
               if (hit_before) begin
                  hi_in  = addr_ff;
                  xhi_in = $signed(bus_ff);
               end else begin
                  lo_in  = addr_ff;
                  xlo_in = $signed(bus_ff);
               end
            end
         end
         sgfi_pkg::S_PREP: begin
            res_st_in = sgfi_pkg::ST_OK;
            if (den_ff <= 0 || num_ff <= 0) begin
               res_idx_in = make_index(lo_ff, '0);
            end else if (num_ff >= den_ff) begin
               res_idx_in = make_index(lo_ff, (F+1)'(1) << F);
            end else begin
               div_start = 1'b1;
            end
         end
         sgfi_pkg::S_DIVIDE: begin
            if (div_done) res_idx_in = make_index(lo_ff, {1'b0, div_quot});
         end
         sgfi_pkg::S_DONE: begin
            if (slot_free) begin
               load     = 1'b1;
               load_idx = res_idx_ff;
               load_st  = res_st_ff;
            end
         end
         default: ;
      endcase

      wait_in = issue ? 2'd0 : (fetch_done ? wait_ff : wait_ff + 2'd1);

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_st_in    = rsp_st_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = load_idx;
         rsp_st_in    = load_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgfi_pkg::S_IDLE;
         order_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wen) order_ff <= csr_wdata;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      settle_ff  <= settle_in;
      coord_ff   <= coord_in;
      off_ff     <= off_in;
      q_ff       <= q_in;
      first_ff   <= first_in;
      xlo_ff     <= xlo_in;
      xhi_ff     <= xhi_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      addr_ff    <= addr_in;
      wait_ff    <= wait_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      res_idx_ff <= res_idx_in;
      res_st_ff  <= res_st_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_st_ff  <= rsp_st_in;
      bus_ff     <= bus_or;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - sgfi_pkg::INDEX_W){1'b0}}, rsp_idx_ff};
   assign rsp_tuser  = rsp_st_ff;

   `SGFI_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(MAX_POINTS))
   `SGFI_ASSERT_NOW(a_err_zero_index, rsp_valid_ff && rsp_st_ff != sgfi_pkg::ST_OK,
      rsp_idx_ff == '0)
   `SGFI_ASSERT_NEXT(a_accept_progress, accept,
      state_ff != sgfi_pkg::S_IDLE || rsp_valid_ff)
   `SGFI_ASSERT_NOW(a_search_order, state_ff == sgfi_pkg::S_SEARCH, hi_ff > lo_ff)

endmodule

// File: test/sorted_grid_fractional_index_top_tb.sv
// Testbench for the sorted grid fractional index block: table building and lookups
`timescale 1ns / 100ps

module sorted_grid_fractional_index_top_tb;

   localparam int TABLE_DEPTH = 256;
   localparam int FRAC_BITS   = 16;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [24:0] index;
      logic [1:0]  status;
   } lookup_result_type;

   class lookup_scoreboard;
      logic signed [31:0] grid [TABLE_DEPTH];
      int                 count;
      logic               descending;
      lookup_result_type  pending [$];
      int                 errors;

      function void clear_state();
         count = 0;
         descending = 1'b0;
         errors = 0;
      endfunction

      function bit precedes(logic signed [33:0] a, logic signed [33:0] b);
         return descending ? (a > b) : (a < b);
      endfunction

      function void note_word(logic [1:0] action, logic signed [31:0] coord,
                              logic signed [31:0] offset);
         lookup_result_type  r;
         int                 pos;
         int                 lo;
         int                 hi;
         int                 mid;
         logic signed [33:0] q;
         logic signed [33:0] first;
         logic signed [33:0] last;
         logic signed [33:0] num;
         logic signed [33:0] den;
         logic [63:0]        frac;
         r.index = '0;
         r.status = sgfi_pkg::ST_OK;
         if (action == sgfi_pkg::ACT_CLEAR) begin
            count = 0;
         end else if (action == sgfi_pkg::ACT_INSERT) begin
            if (count >= TABLE_DEPTH) begin
               r.status = sgfi_pkg::ST_FULL;
            end else begin
               pos = count;
               while (pos > 0 && precedes(coord, grid[pos-1])) pos--;
               for (int i = count; i > pos; i--) grid[i] = grid[i-1];
               grid[pos] = coord;
               count++;
            end
         end else if (action == sgfi_pkg::ACT_QUERY) begin
            if (count < 2) begin
               r.status = sgfi_pkg::ST_FEW;
            end else begin
               first = grid[0];
               last = grid[count-1];
               q = descending ? first - offset : first + offset;
               if (descending ? (q > first || q < last) : (q < first || q > last)) begin
                  r.status = sgfi_pkg::ST_RANGE;
               end else begin
                  lo = 0;
                  hi = count - 1;
                  while (hi - lo > 1) begin
                     mid = lo + (hi - lo) / 2;
                     if (precedes(q, grid[mid])) hi = mid;
                     else lo = mid;
                  end
                  if (descending) begin
                     num = grid[lo] - q;
                     den = grid[lo] - grid[hi];
                  end else begin
                     num = q - grid[lo];
                     den = grid[hi] - grid[lo];
                  end
                  if (den <= 0 || num <= 0) frac = 0;
                  else if (num >= den) frac = 64'd1 << FRAC_BITS;
                  else frac = (64'(num) << FRAC_BITS) / 64'(den);
                  r.index = 25'((64'(lo) << FRAC_BITS) + frac);
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_word(logic [31:0] data, logic [1:0] status);
         lookup_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected word: index %0h status %0d", data, status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data !== {7'd0, e.index}) begin
            $error("fractional_index: expected %0h actual %0h", e.index, data);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic        csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   lookup_scoreboard sb;
   int               cycles;
   int               burst_left;
   bit               stall_mode;

   sorted_grid_fractional_index_top u_dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("sorted_grid_fractional_index_top_tb: FAIL");
            $finish;
         end
      end
   end

   // receiver: stall pattern alternates between calm and choppy stretches
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser);
   end

   initial begin
      rsp_tready = 1'b0;
      stall_mode = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   task automatic send_word(logic [1:0] action, logic [31:0] coord, logic [31:0] offset);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {offset, coord};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(action, coord, offset);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_order(logic order);
      csr_wen <= 1'b1;
      csr_wdata <= order;
      @(negedge clock);
      csr_wen <= 1'b0;
      sb.descending = order;
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
         default: return $urandom_range(0, 255) << $urandom_range(0, 20);
      endcase
   endfunction

   task automatic random_phase(int words, int pts);
      int mode;
      int r;
      logic [31:0] span;
      mode = $urandom_range(0, 2);
      send_word(sgfi_pkg::ACT_CLEAR, $urandom(), $urandom());
      for (int i = 0; i < pts; i++)
         send_word(sgfi_pkg::ACT_INSERT, rand_coord(mode), $urandom());
      for (int i = 0; i < words; i++) begin
         r = $urandom_range(0, 99);
         span = sb.count >= 2 ? sb.grid[sb.count-1] - sb.grid[0] : 32'd100;
         if (sb.descending) span = -span;
         if (r < 70)
            send_word(sgfi_pkg::ACT_QUERY, $urandom(),
                      (span == 0) ? 32'd0 : 32'($urandom() % ({1'b0, span} + 33'd1)));
         else if (r < 80) send_word(sgfi_pkg::ACT_QUERY, $urandom(), $urandom());
         else if (r < 92) send_word(sgfi_pkg::ACT_INSERT, rand_coord(mode), $urandom());
         else if (r < 97) send_word(2'd3, $urandom(), $urandom());
         else send_word(sgfi_pkg::ACT_CLEAR, $urandom(), $urandom());
      end
   endtask

   initial begin
      sb = new();
      sb.clear_state();
      burst_left = 0;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = sgfi_pkg::ACT_CLEAR;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // directed: few points, extremes, ties, unused code, range edges
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'd0);
      send_word(sgfi_pkg::ACT_INSERT, 32'h8000_0000, 32'd0);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'd0);
      send_word(sgfi_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(sgfi_pkg::ACT_INSERT, 32'h0001_0000, 32'd0);
      send_word(sgfi_pkg::ACT_INSERT, 32'h0001_0000, 32'd0);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'hFFFF_FFFF);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'h8001_0000);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'h7FFF_FFFF);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'h8000_0000);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'd0);
      send_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(sgfi_pkg::ACT_CLEAR, 32'd0, 32'd0);
      for (int i = 0; i < TABLE_DEPTH + 2; i++)
         send_word(sgfi_pkg::ACT_INSERT, $urandom_range(0, 300) << 12, 32'd0);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'd0);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'h0012_C000);
      wait_idle();

      // order flipped on a filled table, no re-sort
      write_order(1'b1);
      send_word(sgfi_pkg::ACT_QUERY, 32'd0, 32'h0000_1000);
      send_word(sgfi_pkg::ACT_INSERT, 32'h0000_5000, 32'd0);
      random_phase(40, 0);
      wait_idle();
      write_order(1'b0);

      for (int p = 0; p < 16; p++) begin
         random_phase(55, (p % 5 == 4) ? 200 : $urandom_range(2, 20));
         wait_idle();
         write_order($urandom_range(0, 1));
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("sorted_grid_fractional_index_top_tb: PASS");
      else
         $display("sorted_grid_fractional_index_top_tb: FAIL");
      $finish;
   end
endmodule
